>>> hw/rtl/pomc_pkg.sv
// Shared types, widths and saturation helpers for the pendulum cart controller.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package pomc_pkg;

    localparam int Q_W       = 32;
    localparam int ACC_W     = 66;
    localparam int MP_W      = 32;
    localparam int DRV_W     = 14;
    localparam int SAMPLE_W  = 12;
    localparam int X2_W      = 36;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ANGLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_RATE  = 1'b1;

    typedef logic signed [Q_W-1:0]   q_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [DRV_W-1:0] drv_t;
    typedef logic signed [MP_W-1:0]  mp_t;

    typedef struct packed {
        logic mul_go;
        logic div_go;
        logic clear;
    } alu_cmd_t;

    localparam acc_t Q_MAX  = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam acc_t Q_MIN  = {{(ACC_W-31){1'b1}}, {31{1'b0}}};
    localparam acc_t FB_LIM = {{(ACC_W-41){1'b0}}, 1'b1, {40{1'b0}}};

    function automatic q_t sat32(acc_t v);
        q_t r;
        if (v > Q_MAX)
        begin
            r = Q_MAX[Q_W-1:0];
        end
        else if (v < Q_MIN)
        begin
            r = Q_MIN[Q_W-1:0];
        end
        else
        begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    function automatic acc_t clamp_sym(acc_t v, acc_t lim);
        acc_t r;
        if (v > lim)
        begin
            r = lim;
        end
        else if (v < -lim)
        begin
            r = -lim;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pomc_ifs.sv
// Valid/ready channel interfaces: tick samples, result words and gain writes.
// Depends on pomc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pomc_tick_if import pomc_pkg::*; ;
    logic                valid;
    logic                ready;
    logic                action;
    logic                control_enable;
    q_t                  left_count;
    q_t                  right_count;
    logic [SAMPLE_W-1:0] pendulum_sample;

    modport source (output valid, action, control_enable, left_count, right_count,
                    pendulum_sample, input ready);
    modport sink (input valid, action, control_enable, left_count, right_count,
                  pendulum_sample, output ready);
endinterface

interface pomc_result_if import pomc_pkg::*; ;
    logic valid;
    logic ready;
    drv_t left_drive_mv;
    drv_t right_drive_mv;
    q_t   left_speed;
    q_t   est_angle;
    q_t   est_rate;
    q_t   pendulum_rate;
    q_t   cart_speed;
    q_t   pendulum_angle;

    modport source (output valid, left_drive_mv, right_drive_mv, left_speed, est_angle,
                    est_rate, pendulum_rate, cart_speed, pendulum_angle, input ready);
    modport sink (input valid, left_drive_mv, right_drive_mv, left_speed, est_angle,
                  est_rate, pendulum_rate, cart_speed, pendulum_angle, output ready);
endinterface

interface pomc_cfg_if import pomc_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    q_t                   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pomc_alu.sv
// Bit-serial multiply-accumulate and rounding divide unit, shared by all steps.
// Depends on pomc_pkg for widths and the command struct.
`timescale 1ns / 1ps
`default_nettype none

module pomc_alu
    import pomc_pkg::*;
#(
    parameter int DEN_W = 17
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire alu_cmd_t         cmd,
    input  wire acc_t             mcand,
    input  wire mp_t              mplier,
    input  wire logic [DEN_W-1:0] den,
    output acc_t                  acc,
    output acc_t                  quot,
    output logic                  done
);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_MUL  = 2'd1;
    localparam logic [1:0] A_PREP = 2'd2;
    localparam logic [1:0] A_DIV  = 2'd3;
    localparam int CNT_W = $clog2(ACC_W);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MP_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ACC_W - 1);

    logic [1:0]       state_reg;
    logic [CNT_W-1:0] cnt_reg;
    acc_t             acc_reg;
    acc_t             mc_reg;
    mp_t              mp_reg;
    logic [ACC_W-1:0] mag_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic             done_reg;

    acc_t           addend;
    logic [DEN_W:0] shifted;
    logic [DEN_W:0] trial;
    logic           qbit;

    always_comb
    begin
        if (mp_reg[0])
        begin
            addend = (cnt_reg == MUL_LAST) ? -mc_reg : mc_reg;
        end
        else
        begin
            addend = '0;
        end
        shifted = {rem_reg, mag_reg[ACC_W-1]};
        trial   = shifted - {1'b0, den_reg};
        qbit    = ~trial[DEN_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE:
                begin
                    if (cmd.mul_go)
                    begin
                        if (cmd.clear)
                        begin
                            acc_reg <= '0;
                        end
                        mc_reg    <= mcand;
                        mp_reg    <= mplier;
                        cnt_reg   <= '0;
                        state_reg <= A_MUL;
                    end
                    else if (cmd.div_go)
                    begin
                        neg_reg   <= acc_reg[ACC_W-1];
                        mag_reg   <= acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
                        den_reg   <= den;
                        state_reg <= A_PREP;
                    end
                end
                A_MUL:
                begin
                    acc_reg <= acc_reg + addend;
                    mc_reg  <= mc_reg <<< 1;
                    mp_reg  <= mp_reg >>> 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == MUL_LAST)
                    begin
                        state_reg <= A_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                A_PREP:
                begin
                    mag_reg   <= mag_reg + ACC_W'(den_reg >> 1);
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= A_DIV;
                end
                A_DIV:
                begin
                    rem_reg <= qbit ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
                    mag_reg <= {mag_reg[ACC_W-2:0], qbit};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        state_reg <= A_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign acc  = acc_reg;
    assign quot = neg_reg ? -acc_t'(mag_reg) : acc_t'(mag_reg);
    assign done = done_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pendulum_observer_pi_motor_control.sv
// Pendulum cart controller: angle and speed sensing, two-state observer, state
// feedback and incremental PI drive per wheel. Uses pomc_pkg, pomc_ifs, pomc_alu.
//
// Channels: tick carries one control tick (clear action, enable, two encoder
// counts and the pendulum converter sample); result returns one word per tick
// with both drive voltages and the sensed and estimated quantities; cfg writes
// the two feedback gains (index 0 angle gain, index 1 rate gain) and is always
// ready. Gains should only be written while no tick is in flight.
// A clear or a disabled tick goes straight to the output state with no arithmetic.
// An enabled tick runs 21 serial multiply passes on one shared unit, 12 of them
// followed by a rounding divide; that unit sets the throughput, and one tick is
// processed at a time.
// Reset clears the gains and all controller state; no word is pending after it.
// The result word sits in an output register: a new tick is accepted while it
// waits, and a finished tick waits in place until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module pendulum_observer_pi_motor_control
    import pomc_pkg::*;
#(
    parameter int FRAC_BITS      = 16,
    parameter int DRIVE_LIMIT_MV = 6000
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    pomc_cfg_if.sink      cfg,
    pomc_tick_if.sink     tick,
    pomc_result_if.source result
);

    localparam int DEN_W = (FRAC_BITS + 1 > 17) ? FRAC_BITS + 1 : 17;
    localparam logic [DEN_W-1:0] QONE_DEN = {{(DEN_W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam acc_t DRV_LIM = ACC_W'(DRIVE_LIMIT_MV);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_ISSUE = 3'd1;
    localparam logic [2:0] PH_MUL   = 3'd2;
    localparam logic [2:0] PH_DIV   = 3'd3;
    localparam logic [2:0] PH_OUT   = 3'd4;

    localparam logic [STEP_W-1:0] ST_ANGLE = 5'd0;
    localparam logic [STEP_W-1:0] ST_PRATE = 5'd1;
    localparam logic [STEP_W-1:0] ST_V1    = 5'd2;
    localparam logic [STEP_W-1:0] ST_V2    = 5'd3;
    localparam logic [STEP_W-1:0] ST_CART  = 5'd4;
    localparam logic [STEP_W-1:0] ST_X2    = 5'd5;
    localparam logic [STEP_W-1:0] ST_E1A   = 5'd6;
    localparam logic [STEP_W-1:0] ST_E1B   = 5'd7;
    localparam logic [STEP_W-1:0] ST_E1C   = 5'd8;
    localparam logic [STEP_W-1:0] ST_E1D   = 5'd9;
    localparam logic [STEP_W-1:0] ST_E2A   = 5'd10;
    localparam logic [STEP_W-1:0] ST_E2B   = 5'd11;
    localparam logic [STEP_W-1:0] ST_E2C   = 5'd12;
    localparam logic [STEP_W-1:0] ST_E2D   = 5'd13;
    localparam logic [STEP_W-1:0] ST_FBA   = 5'd14;
    localparam logic [STEP_W-1:0] ST_FBR   = 5'd15;
    localparam logic [STEP_W-1:0] ST_WREF  = 5'd16;
    localparam logic [STEP_W-1:0] ST_ULA   = 5'd17;
    localparam logic [STEP_W-1:0] ST_ULB   = 5'd18;
    localparam logic [STEP_W-1:0] ST_URA   = 5'd19;
    localparam logic [STEP_W-1:0] ST_URB   = 5'd20;

    q_t gain_angle_reg;
    q_t gain_rate_reg;

    q_t          last_angle_reg;
    logic [31:0] last_left_pos_reg;
    logic [31:0] last_right_pos_reg;
    q_t          est_angle_reg;
    q_t          est_rate_reg;
    q_t          left_prev_error_reg;
    q_t          right_prev_error_reg;
    drv_t        left_drive_reg;
    drv_t        right_drive_reg;

    logic [2:0]          phase_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [31:0]         lp_reg;
    logic [31:0]         rp_reg;

    q_t                    ang_reg;
    q_t                    prate_reg;
    q_t                    v1_reg;
    q_t                    v2_reg;
    q_t                    cart_reg;
    logic signed [X2_W-1:0] x2_reg;
    q_t                    ne1_reg;
    q_t                    ne2_reg;
    acc_t                  fb_reg;
    q_t                    el_reg;
    q_t                    erw_reg;
    drv_t                  ul_reg;
    drv_t                  ur_reg;

    logic out_valid_reg;
    drv_t out_ld_reg;
    drv_t out_rd_reg;
    q_t   out_ls_reg;
    q_t   out_ea_reg;
    q_t   out_er_reg;
    q_t   out_pr_reg;
    q_t   out_cs_reg;
    q_t   out_pa_reg;

    alu_cmd_t         cmd;
    acc_t             mcand;
    mp_t              mplier;
    logic [DEN_W-1:0] den;
    logic             clr;
    logic             has_div;
    acc_t             alu_acc;
    acc_t             alu_quot;
    logic             alu_done;

    q_t                   d1;
    q_t                   d2;
    logic signed [12:0]   s_off;
    acc_t                 n1;
    acc_t                 n2;
    acc_t                 fbc;
    acc_t                 res;
    q_t                   wref;
    drv_t                 ul_val;
    drv_t                 ur_val;
    logic                 wb_en;
    logic                 tick_fire;
    logic                 out_free;

    assign d1    = q_t'(lp_reg - last_left_pos_reg);
    assign d2    = q_t'(rp_reg - last_right_pos_reg);
    assign s_off = $signed({1'b0, sample_reg}) - 13'sd367;
    assign n1    = acc_t'(ang_reg) - acc_t'(est_angle_reg);
    assign n2    = acc_t'(x2_reg) - acc_t'(est_rate_reg);
    assign fbc   = clamp_sym(-fb_reg, FB_LIM);

    assign res    = (phase_reg == PH_DIV) ? alu_quot : alu_acc;
    assign wref   = sat32(res);
    assign ul_val = drv_t'(clamp_sym(acc_t'(left_drive_reg) + res, DRV_LIM));
    assign ur_val = drv_t'(clamp_sym(acc_t'(right_drive_reg) + res, DRV_LIM));

    always_comb
    begin
        mcand   = '0;
        mplier  = '0;
        den     = QONE_DEN;
        clr     = 1'b1;
        has_div = 1'b0;
        unique case (step_reg)
            ST_ANGLE:
            begin
                mcand   = acc_t'(s_off) <<< FRAC_BITS;
                mplier  = 32'sd628;
                den     = DEN_W'(102400);
                has_div = 1'b1;
            end
            ST_PRATE:
            begin
                mcand  = acc_t'(ang_reg) - acc_t'(last_angle_reg);
                mplier = 32'sd100;
            end
            ST_V1:
            begin
                mcand   = acc_t'(d1) <<< FRAC_BITS;
                mplier  = 32'sd2;
                den     = DEN_W'(5);
                has_div = 1'b1;
            end
            ST_V2:
            begin
                mcand   = acc_t'(d2) <<< FRAC_BITS;
                mplier  = 32'sd2;
                den     = DEN_W'(5);
                has_div = 1'b1;
            end
            ST_CART:
            begin
                mcand   = (acc_t'(d1) + acc_t'(d2)) <<< FRAC_BITS;
                mplier  = 32'sd13;
                den     = DEN_W'(2000);
                has_div = 1'b1;
            end
            ST_X2:
            begin
                mcand   = acc_t'(cart_reg);
                mplier  = 32'sd741;
                den     = DEN_W'(100);
                has_div = 1'b1;
            end
            ST_E1A:
            begin
                mcand  = acc_t'(est_angle_reg);
                mplier = 32'sd10034;
            end
            ST_E1B:
            begin
                mcand  = acc_t'(est_rate_reg);
                mplier = 32'sd100;
                clr    = 1'b0;
            end
            ST_E1C:
            begin
                mcand  = n1;
                mplier = 32'sd895;
                clr    = 1'b0;
            end
            ST_E1D:
            begin
                mcand   = n2;
                mplier  = 32'sd100;
                clr     = 1'b0;
                den     = DEN_W'(10000);
                has_div = 1'b1;
            end
            ST_E2A:
            begin
                mcand  = acc_t'(est_angle_reg);
                mplier = 32'sd6847;
            end
            ST_E2B:
            begin
                mcand  = acc_t'(est_rate_reg);
                mplier = 32'sd10034;
                clr    = 1'b0;
            end
            ST_E2C:
            begin
                mcand  = n1;
                mplier = 32'sd6847;
                clr    = 1'b0;
            end
            ST_E2D:
            begin
                mcand   = n2;
                mplier  = 32'sd922;
                clr     = 1'b0;
                den     = DEN_W'(10000);
                has_div = 1'b1;
            end
            ST_FBA:
            begin
                mcand   = acc_t'(ne1_reg);
                mplier  = gain_angle_reg;
                has_div = 1'b1;
            end
            ST_FBR:
            begin
                mcand   = acc_t'(ne2_reg);
                mplier  = gain_rate_reg;
                has_div = 1'b1;
            end
            ST_WREF:
            begin
                mcand   = fbc;
                mplier  = 32'sd400;
                den     = DEN_W'(13);
                has_div = 1'b1;
            end
            ST_ULA:
            begin
                mcand  = acc_t'(el_reg);
                mplier = 32'sd6000;
            end
            ST_ULB:
            begin
                mcand   = acc_t'(left_prev_error_reg);
                mplier  = -32'sd2400;
                clr     = 1'b0;
                has_div = 1'b1;
            end
            ST_URA:
            begin
                mcand  = acc_t'(erw_reg);
                mplier = 32'sd6000;
            end
            ST_URB:
            begin
                mcand   = acc_t'(right_prev_error_reg);
                mplier  = -32'sd2400;
                clr     = 1'b0;
                has_div = 1'b1;
            end
            default:
            begin
                mcand = '0;
            end
        endcase
    end

    assign cmd.mul_go = (phase_reg == PH_ISSUE);
    assign cmd.clear  = clr;
    assign cmd.div_go = (phase_reg == PH_MUL) && alu_done && has_div;

    assign wb_en = ((phase_reg == PH_MUL) && alu_done && !has_div)
                || ((phase_reg == PH_DIV) && alu_done);

    assign tick_fire = tick.valid && tick.ready;
    assign out_free  = !out_valid_reg || result.ready;

    pomc_alu #(
        .DEN_W (DEN_W)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .mcand  (mcand),
        .mplier (mplier),
        .den    (den),
        .acc    (alu_acc),
        .quot   (alu_quot),
        .done   (alu_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_angle_reg       <= '0;
            gain_rate_reg        <= '0;
            last_angle_reg       <= '0;
            last_left_pos_reg    <= '0;
            last_right_pos_reg   <= '0;
            est_angle_reg        <= '0;
            est_rate_reg         <= '0;
            left_prev_error_reg  <= '0;
            right_prev_error_reg <= '0;
            left_drive_reg       <= '0;
            right_drive_reg      <= '0;
            phase_reg            <= PH_IDLE;
            step_reg             <= ST_ANGLE;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_GAIN_ANGLE: gain_angle_reg <= cfg.data;
                    REG_GAIN_RATE:  gain_rate_reg  <= cfg.data;
                    default:        gain_rate_reg  <= gain_rate_reg;
                endcase
            end

            if ((phase_reg == PH_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (tick_fire)
                    begin
                        if (tick.action)
                        begin
                            last_angle_reg       <= '0;
                            last_left_pos_reg    <= '0;
                            last_right_pos_reg   <= '0;
                            est_angle_reg        <= '0;
                            est_rate_reg         <= '0;
                            left_prev_error_reg  <= '0;
                            right_prev_error_reg <= '0;
                            left_drive_reg       <= '0;
                            right_drive_reg      <= '0;
                            ul_reg    <= '0;
                            ur_reg    <= '0;
                            v1_reg    <= '0;
                            ne1_reg   <= '0;
                            ne2_reg   <= '0;
                            prate_reg <= '0;
                            cart_reg  <= '0;
                            ang_reg   <= '0;
                            phase_reg <= PH_OUT;
                        end
                        else if (!tick.control_enable)
                        begin
                            ul_reg     <= '0;
                            ur_reg     <= '0;
                            v1_reg     <= '0;
                            ne1_reg    <= est_angle_reg;
                            ne2_reg    <= est_rate_reg;
                            prate_reg  <= '0;
                            cart_reg   <= '0;
                            ang_reg    <= last_angle_reg;
                            phase_reg  <= PH_OUT;
                        end
                        else
                        begin
                            sample_reg <= tick.pendulum_sample;
                            lp_reg     <= 32'd0 - tick.left_count;
                            rp_reg     <= tick.right_count;
                            step_reg   <= ST_ANGLE;
                            phase_reg  <= PH_ISSUE;
                        end
                    end
                end
                PH_ISSUE:
                begin
                    phase_reg <= PH_MUL;
                end
                PH_MUL, PH_DIV:
                begin
                    if ((phase_reg == PH_MUL) && alu_done && has_div)
                    begin
                        phase_reg <= PH_DIV;
                    end
                    else if (wb_en)
                    begin
                        unique case (step_reg)
                            ST_ANGLE: ang_reg   <= sat32(res);
                            ST_PRATE: prate_reg <= sat32(res);
                            ST_V1:    v1_reg    <= sat32(res);
                            ST_V2:    v2_reg    <= sat32(res);
                            ST_CART:  cart_reg  <= sat32(res);
                            ST_X2:    x2_reg    <= X2_W'(prate_reg) - res[X2_W-1:0];
                            ST_E1D:   ne1_reg   <= sat32(res);
                            ST_E2D:   ne2_reg   <= sat32(res);
                            ST_FBA:   fb_reg    <= res;
                            ST_FBR:   fb_reg    <= fb_reg + res;
                            ST_WREF:
                            begin
                                el_reg  <= sat32(acc_t'(wref) - acc_t'(v1_reg));
                                erw_reg <= sat32(acc_t'(wref) - acc_t'(v2_reg));
                            end
                            ST_ULB:   ul_reg    <= ul_val;
                            ST_URB:   ur_reg    <= ur_val;
                            default:  fb_reg    <= fb_reg;
                        endcase
                        if (step_reg == ST_URB)
                        begin
                            last_angle_reg       <= ang_reg;
                            last_left_pos_reg    <= lp_reg;
                            last_right_pos_reg   <= rp_reg;
                            est_angle_reg        <= ne1_reg;
                            est_rate_reg         <= ne2_reg;
                            left_prev_error_reg  <= el_reg;
                            right_prev_error_reg <= erw_reg;
                            left_drive_reg       <= ul_reg;
                            right_drive_reg      <= ur_val;
                            phase_reg            <= PH_OUT;
                        end
                        else
                        begin
                            step_reg  <= step_reg + 1'b1;
                            phase_reg <= PH_ISSUE;
                        end
                    end
                end
                PH_OUT:
                begin
                    if (out_free)
                    begin
                        out_ld_reg    <= ul_reg;
                        out_rd_reg    <= ur_reg;
                        out_ls_reg    <= v1_reg;
                        out_ea_reg    <= ne1_reg;
                        out_er_reg    <= ne2_reg;
                        out_pr_reg    <= prate_reg;
                        out_cs_reg    <= cart_reg;
                        out_pa_reg    <= ang_reg;
                        phase_reg     <= PH_IDLE;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    assign cfg.ready  = 1'b1;
    assign tick.ready = (phase_reg == PH_IDLE);

    assign result.valid          = out_valid_reg;
    assign result.left_drive_mv  = out_ld_reg;
    assign result.right_drive_mv = out_rd_reg;
    assign result.left_speed     = out_ls_reg;
    assign result.est_angle      = out_ea_reg;
    assign result.est_rate       = out_er_reg;
    assign result.pendulum_rate  = out_pr_reg;
    assign result.cart_speed     = out_cs_reg;
    assign result.pendulum_angle = out_pa_reg;

endmodule

`default_nettype wire
